// ===== sv/lfu_cache_lookup_replace_unit_macros.svh =====
// Assertion helpers for the LFU cache block.
`ifndef LFU_CACHE_LOOKUP_REPLACE_UNIT_MACROS_SVH
`define LFU_CACHE_LOOKUP_REPLACE_UNIT_MACROS_SVH

// Property that must hold at every edge outside reset.
`define LFU_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Implication checked at the same edge.
`define LFU_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== sv/lfu_pkg.sv =====
`default_nettype none
package lfu_pkg;

  localparam int unsigned CAPACITY_DEF   = 16;
  localparam int unsigned COUNT_BITS_DEF = 16;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 31;
  localparam int unsigned CFG_W = 5;
  localparam logic [CFG_W-1:0] CAP_RST = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // flags riding with the scan packet down the chain
  typedef struct packed {
    logic vld;
    logic hit;
    logic vic;
    logic free;
  } lfu_scan_flags_t;

  // update broadcast to all cells
  typedef struct packed {
    logic bump;
    logic wr_val;
    logic insert;
    logic evict;
  } lfu_upd_cmd_t;

endpackage
`default_nettype wire

// ===== sv/lfu_cell.sv =====
`default_nettype none
module lfu_cell #(
  parameter int unsigned IDX        = 0,
  parameter int unsigned IW         = 4,
  parameter int unsigned COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // scan packet from left neighbor
  input  wire lfu_pkg::lfu_scan_flags_t      fl_i,
  input  wire logic [lfu_pkg::KEY_W-1:0]     pk_key_i,
  input  wire logic [IW-1:0]                 hit_idx_i,
  input  wire logic [lfu_pkg::VAL_W-1:0]     hit_val_i,
  input  wire logic [IW-1:0]                 hit_rank_i,
  input  wire logic [IW-1:0]                 vic_idx_i,
  input  wire logic [COUNT_BITS-1:0]         vic_cnt_i,
  input  wire logic [IW-1:0]                 vic_rank_i,
  input  wire logic [lfu_pkg::KEY_W-1:0]     vic_key_i,
  input  wire logic [IW-1:0]                 free_idx_i,
  // scan packet to right neighbor
  output lfu_pkg::lfu_scan_flags_t           fl_o,
  output logic [lfu_pkg::KEY_W-1:0]          pk_key_o,
  output logic [IW-1:0]                      hit_idx_o,
  output logic [lfu_pkg::VAL_W-1:0]          hit_val_o,
  output logic [IW-1:0]                      hit_rank_o,
  output logic [IW-1:0]                      vic_idx_o,
  output logic [COUNT_BITS-1:0]              vic_cnt_o,
  output logic [IW-1:0]                      vic_rank_o,
  output logic [lfu_pkg::KEY_W-1:0]          vic_key_o,
  output logic [IW-1:0]                      free_idx_o,
  // update broadcast
  input  wire lfu_pkg::lfu_upd_cmd_t         cmd_i,
  input  wire logic [IW-1:0]                 tgt_idx_i,
  input  wire logic [IW-1:0]                 tgt_rank_i,
  input  wire logic [IW-1:0]                 bc_vic_idx_i,
  input  wire logic [IW-1:0]                 bc_vic_rank_i,
  input  wire logic [lfu_pkg::KEY_W-1:0]     bc_key_i,
  input  wire logic [lfu_pkg::VAL_W-1:0]     bc_val_i,
  output logic                               valid_o
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic                      valid_r, valid_nxt;
  logic [lfu_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [lfu_pkg::VAL_W-1:0] val_r, val_nxt;
  logic [COUNT_BITS-1:0]     cnt_r, cnt_nxt;
  logic [IW-1:0]             rank_r, rank_nxt;

  lfu_pkg::lfu_scan_flags_t  fl_r, fl_nxt;
  logic [lfu_pkg::KEY_W-1:0] pk_key_r;
  logic [IW-1:0]             hit_idx_r, hit_idx_nxt, hit_rank_r, hit_rank_nxt;
  logic [lfu_pkg::VAL_W-1:0] hit_val_r, hit_val_nxt;
  logic [IW-1:0]             vic_idx_r, vic_idx_nxt, vic_rank_r, vic_rank_nxt;
  logic [COUNT_BITS-1:0]     vic_cnt_r, vic_cnt_nxt;
  logic [lfu_pkg::KEY_W-1:0] vic_key_r, vic_key_nxt;
  logic [IW-1:0]             free_idx_r, free_idx_nxt;

  logic take_hit, take_vic, take_free, is_tgt, is_vic;

  // scan step: first match, least-used/oldest victim, first free slot
  always_comb begin
    take_hit  = !fl_i.hit && valid_r && (key_r == pk_key_i);
    take_vic  = valid_r && (!fl_i.vic || (cnt_r < vic_cnt_i) ||
                ((cnt_r == vic_cnt_i) && (rank_r > vic_rank_i)));
    take_free = !valid_r && !fl_i.free;

    fl_nxt       = fl_i;
    fl_nxt.hit   = fl_i.hit | take_hit;
    fl_nxt.vic   = fl_i.vic | take_vic;
    fl_nxt.free  = fl_i.free | take_free;
    hit_idx_nxt  = take_hit ? MY_IDX : hit_idx_i;
    hit_val_nxt  = take_hit ? val_r  : hit_val_i;
    hit_rank_nxt = take_hit ? rank_r : hit_rank_i;
    vic_idx_nxt  = take_vic ? MY_IDX : vic_idx_i;
    vic_cnt_nxt  = take_vic ? cnt_r  : vic_cnt_i;
    vic_rank_nxt = take_vic ? rank_r : vic_rank_i;
    vic_key_nxt  = take_vic ? key_r  : vic_key_i;
    free_idx_nxt = take_free ? MY_IDX : free_idx_i;
  end

  // entry update from the broadcast
  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    val_nxt   = val_r;
    cnt_nxt   = cnt_r;
    rank_nxt  = rank_r;
    is_tgt    = (tgt_idx_i == MY_IDX);
    is_vic    = cmd_i.evict && (bc_vic_idx_i == MY_IDX);
    if (cmd_i.bump) begin
      if (is_tgt) begin
        if (cnt_r != CNT_MAX) cnt_nxt = cnt_r + 1'b1;
        rank_nxt = '0;
        if (cmd_i.wr_val) val_nxt = bc_val_i;
      end else if (valid_r && (rank_r < tgt_rank_i)) begin
        rank_nxt = rank_r + 1'b1;
      end
    end else if (cmd_i.insert) begin
      if (is_tgt) begin
        valid_nxt = 1'b1;
        key_nxt   = bc_key_i;
        val_nxt   = bc_val_i;
        cnt_nxt   = COUNT_BITS'(1);
        rank_nxt  = '0;
      end else if (is_vic) begin
        valid_nxt = 1'b0;
      end else if (valid_r) begin
        // evict closes the gap above the victim, insert ages everyone
        if (!(cmd_i.evict && (rank_r > bc_vic_rank_i))) rank_nxt = rank_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      fl_r    <= '0;
    end else begin
      valid_r <= valid_nxt;
      fl_r    <= fl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    val_r      <= val_nxt;
    cnt_r      <= cnt_nxt;
    rank_r     <= rank_nxt;
    pk_key_r   <= pk_key_i;
    hit_idx_r  <= hit_idx_nxt;
    hit_val_r  <= hit_val_nxt;
    hit_rank_r <= hit_rank_nxt;
    vic_idx_r  <= vic_idx_nxt;
    vic_cnt_r  <= vic_cnt_nxt;
    vic_rank_r <= vic_rank_nxt;
    vic_key_r  <= vic_key_nxt;
    free_idx_r <= free_idx_nxt;
  end

  assign fl_o       = fl_r;
  assign pk_key_o   = pk_key_r;
  assign hit_idx_o  = hit_idx_r;
  assign hit_val_o  = hit_val_r;
  assign hit_rank_o = hit_rank_r;
  assign vic_idx_o  = vic_idx_r;
  assign vic_cnt_o  = vic_cnt_r;
  assign vic_rank_o = vic_rank_r;
  assign vic_key_o  = vic_key_r;
  assign free_idx_o = free_idx_r;
  assign valid_o    = valid_r;

endmodule
`default_nettype wire

// ===== sv/lfu_cache_lookup_replace_unit.sv =====
`default_nettype none
// LFU key-value cache, CAPACITY entries, one get or put transaction at a time.
// Entries live in a chain of CAPACITY cells. An accepted transaction sends a
// scan packet down the chain, one cell per cycle, which picks up the first
// key match, the victim (lowest use count, oldest on ties) and the first free
// cell; the packet from the last cell is latched, then in the update state,
// once the output register is free, the update is broadcast to every cell
// and the result register is loaded. The next transaction is accepted as
// soon as the update is done, even while the result still waits for
// out_tready. capacity_in_use is written through cfg_wr_en/cfg_wr_data;
// the user must do so only while idle, as the block does not enforce it;
// values above CAPACITY act as CAPACITY and zero makes puts change nothing.
module lfu_cache_lookup_replace_unit #(
  parameter int unsigned CAPACITY   = lfu_pkg::CAPACITY_DEF,
  parameter int unsigned COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [4:0]  cfg_wr_data,   // capacity_in_use
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,      // key[31:0], value[62:32], zero[63]
  input  wire logic [0:0]  in_tuser,      // operation[0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata      // hit[0], read_value[31:1], evicted[32],
                                          // evicted_key[64:33], zero[71:65]
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned OW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = (OW > lfu_pkg::CFG_W) ? OW : lfu_pkg::CFG_W;
  localparam int unsigned KW = lfu_pkg::KEY_W;
  localparam int unsigned VW = lfu_pkg::VAL_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [lfu_pkg::CFG_W-1:0] cap_r;
  logic [OW-1:0] occ_r, occ_nxt;
  logic op_r;
  logic [KW-1:0] key_r;
  logic [VW-1:0] val_r;

  // chain taps
  lfu_pkg::lfu_scan_flags_t fl_s   [CAPACITY+1];
  logic [KW-1:0]            key_s  [CAPACITY+1];
  logic [IW-1:0]            hidx_s [CAPACITY+1];
  logic [VW-1:0]            hval_s [CAPACITY+1];
  logic [IW-1:0]            hrnk_s [CAPACITY+1];
  logic [IW-1:0]            vidx_s [CAPACITY+1];
  logic [COUNT_BITS-1:0]    vcnt_s [CAPACITY+1];
  logic [IW-1:0]            vrnk_s [CAPACITY+1];
  logic [KW-1:0]            vkey_s [CAPACITY+1];
  logic [IW-1:0]            fidx_s [CAPACITY+1];
  logic [CAPACITY-1:0]      valid_vec;

  // latched scan result
  lfu_pkg::lfu_scan_flags_t sc_fl_r;
  logic [IW-1:0] sc_hidx_r, sc_hrnk_r, sc_vidx_r, sc_vrnk_r, sc_fidx_r;
  logic [VW-1:0] sc_hval_r;
  logic [KW-1:0] sc_vkey_r;

  lfu_pkg::lfu_upd_cmd_t cmd;
  logic [IW-1:0] tgt_idx, slot;
  logic [CW-1:0] cap_eff;
  logic in_acc, upd_go, is_put, cap_nz, miss_put, evict;
  logic out_tvalid_r;
  logic [71:0] out_tdata_r;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);

  assign fl_s[0]   = '{vld: in_acc, hit: 1'b0, vic: 1'b0, free: 1'b0};
  assign key_s[0]  = in_tdata[KW-1:0];
  assign hidx_s[0] = '0;
  assign hval_s[0] = '0;
  assign hrnk_s[0] = '0;
  assign vidx_s[0] = '0;
  assign vcnt_s[0] = '0;
  assign vrnk_s[0] = '0;
  assign vkey_s[0] = '0;
  assign fidx_s[0] = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    lfu_cell #(.IDX(g), .IW(IW), .COUNT_BITS(COUNT_BITS)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .fl_i(fl_s[g]), .pk_key_i(key_s[g]), .hit_idx_i(hidx_s[g]),
      .hit_val_i(hval_s[g]), .hit_rank_i(hrnk_s[g]), .vic_idx_i(vidx_s[g]),
      .vic_cnt_i(vcnt_s[g]), .vic_rank_i(vrnk_s[g]), .vic_key_i(vkey_s[g]),
      .free_idx_i(fidx_s[g]),
      .fl_o(fl_s[g+1]), .pk_key_o(key_s[g+1]), .hit_idx_o(hidx_s[g+1]),
      .hit_val_o(hval_s[g+1]), .hit_rank_o(hrnk_s[g+1]), .vic_idx_o(vidx_s[g+1]),
      .vic_cnt_o(vcnt_s[g+1]), .vic_rank_o(vrnk_s[g+1]), .vic_key_o(vkey_s[g+1]),
      .free_idx_o(fidx_s[g+1]),
      .cmd_i(cmd), .tgt_idx_i(tgt_idx), .tgt_rank_i(sc_hrnk_r),
      .bc_vic_idx_i(sc_vidx_r), .bc_vic_rank_i(sc_vrnk_r),
      .bc_key_i(key_r), .bc_val_i(val_r), .valid_o(valid_vec[g])
    );
  end

  // update decision
  always_comb begin
    cap_eff  = (CW'(cap_r) > CW'(CAPACITY)) ? CW'(CAPACITY) : CW'(cap_r);
    is_put   = (op_r == lfu_pkg::OP_PUT);
    cap_nz   = (cap_r != '0);
    upd_go   = (state_r == ST_UPD) && (!out_tvalid_r || out_tready);
    miss_put = is_put && cap_nz && !sc_fl_r.hit;
    evict    = miss_put && sc_fl_r.vic && (CW'(occ_r) >= cap_eff);
    slot     = (evict && !(sc_fl_r.free && (sc_fidx_r < sc_vidx_r))) ? sc_vidx_r
                                                                   : sc_fidx_r;
    tgt_idx  = sc_fl_r.hit ? sc_hidx_r : slot;
    cmd.bump   = upd_go && sc_fl_r.hit && (!is_put || cap_nz);
    cmd.wr_val = upd_go && sc_fl_r.hit && is_put && cap_nz;
    cmd.evict  = upd_go && evict;
    cmd.insert = upd_go && miss_put && (evict || sc_fl_r.free);
    occ_nxt = occ_r;
    if (cmd.insert && !cmd.evict) occ_nxt = occ_r + 1'b1;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_SCAN;
      ST_SCAN: if (fl_s[CAPACITY].vld) state_nxt = ST_UPD;
      ST_UPD:  if (upd_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cap_r        <= lfu_pkg::CAP_RST;
      occ_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      if (cfg_wr_en) cap_r <= cfg_wr_data;
      if (upd_go) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_tuser[0];
      key_r <= in_tdata[KW-1:0];
      val_r <= in_tdata[KW+VW-1:KW];
    end
    if (fl_s[CAPACITY].vld) begin
      sc_fl_r   <= fl_s[CAPACITY];
      sc_hidx_r <= hidx_s[CAPACITY];
      sc_hval_r <= hval_s[CAPACITY];
      sc_hrnk_r <= hrnk_s[CAPACITY];
      sc_vidx_r <= vidx_s[CAPACITY];
      sc_vrnk_r <= vrnk_s[CAPACITY];
      sc_vkey_r <= vkey_s[CAPACITY];
      sc_fidx_r <= fidx_s[CAPACITY];
    end
    if (upd_go) begin
      out_tdata_r <= {7'd0,
                      evict ? sc_vkey_r : {KW{1'b0}},
                      evict,
                      (sc_fl_r.hit && !is_put) ? sc_hval_r : {VW{1'b0}},
                      sc_fl_r.hit};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`include "lfu_cache_lookup_replace_unit_macros.svh"

  // cell valid bits and the occupancy counter agree
`LFU_ASSERT_ALWAYS(a_occ_match, $countones(valid_vec) == int'(occ_r), "occupancy mismatch")
  // scan packet only leaves the chain while scanning
`LFU_ASSERT_IMPLY(a_scan_state, fl_s[CAPACITY].vld, state_r == ST_SCAN, "stray scan packet")
  // a hit never evicts
`LFU_ASSERT_IMPLY(a_hit_no_evict, out_tvalid_r, !(out_tdata_r[0] && out_tdata_r[32]), "hit evicted")
  // occupancy bounded by the table size
`LFU_ASSERT_ALWAYS(a_occ_bound, int'(occ_r) <= CAPACITY, "occupancy overflow")

endmodule
`default_nettype wire
